// File: src/first_fit_block_allocator_macros.svh
// Assertion macros for the first-fit allocator RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
// Antecedent holds in this cycle, consequent holds in the same cycle.
`define FFBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffba assertion failed: same-cycle implication");
// Antecedent holds in this cycle, consequent holds in the next one.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffba assertion failed: next-cycle implication");
// Expression holds at every clock edge out of reset.
`define FFBA_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ffba assertion failed: invariant");
`else
`define FFBA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define FFBA_ASSERT_ALWAYS(label, clk, rst_n, expr)
`endif

`endif

// File: src/ffba_pkg.sv
// Types and constants of the first-fit block allocator.
package ffba_pkg;

    localparam int SIZE_W = 12;
    localparam int ADDR_W = 16;

    // In-band block header: reserved mark over a payload size.
    typedef struct packed {
        logic              rsv;
        logic [SIZE_W-1:0] size;
    } hdr_t;

    // Request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NOSPACE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_ARENA_BASE  = 1'b0;
    localparam logic CFG_VIRT_OFFSET = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_WR_HDR,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } state_t;

endpackage

// File: src/first_fit_block_allocator.sv
// First-fit block allocator over an in-band header chain held in one memory.
//
//  channel  | direction | beat contents
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | tdata: block_size[11:0], free_address[27:12]
//           |           | tuser: action[0], already_physical[1]
//  m_axis   | out       | tdata: payload_address[15:0]; tuser: status
//  cfg      | in        | cfg_index 0 arena_base, 1 virtual_offset
//
// Allocate: per header walked, a memory read (S_READ), then a check (S_EVAL); the
// single read port sets the walk speed. S_IDLE accepts, S_DONE issues the result;
// an appended block also passes S_WR_HDR; a walk off the arena skips S_EVAL.
// Free: S_FREE_RD, S_FREE_WR, S_DONE, without S_FREE_WR off the arena. No clearing
// pass after reset: a flag makes entry 0 read as a free end marker until written.
// A finished result waits in the output register; the next beat is taken while it
// waits, but a second result stalls until the first one is taken.
`include "first_fit_block_allocator_macros.svh"

module first_fit_block_allocator #(
    parameter int HEAP_UNITS   = 4096,
    parameter int HEADER_UNITS = 1
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // block_size[11:0], free_address[27:12]
    input  logic [1:0]  s_axis_tuser,   // action[0], already_physical[1]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // payload_address[15:0]
    output logic        m_axis_tuser    // status[0]
);

    import ffba_pkg::*;

    localparam int AW = (HEAP_UNITS > 1) ? $clog2(HEAP_UNITS) : 1;
    localparam int PW = ((AW > SIZE_W) ? AW : SIZE_W) + 2;
    localparam logic [PW-1:0] HEAP_P = PW'(HEAP_UNITS);
    localparam logic [PW-1:0] HDR_P  = PW'(HEADER_UNITS);
    localparam logic [ADDR_W-1:0] HDR_A  = ADDR_W'(HEADER_UNITS);
    localparam logic [ADDR_W:0]   HEAP_A = (ADDR_W+1)'(HEAP_UNITS);

    // configuration registers
    logic [ADDR_W-1:0] arena_base_reg;
    logic [ADDR_W-1:0] virt_offset_reg;

    // control and working registers
    state_t            state_reg, state_next;
    logic [PW-1:0]     p_reg;          // header position being walked or freed
    logic [SIZE_W-1:0] req_reg;        // requested size, zero served as one
    logic [ADDR_W-1:0] phys_addr_reg;  // free address without virtual offset
    logic [ADDR_W-1:0] out_bias_reg;   // arena_base + virtual_offset + header
    logic              found_reg;      // allocate succeeded
    logic              nospace_reg;
    logic              e0_written_reg;
    logic              rd_zero_reg;

    // output register
    logic              m_valid_reg;
    logic [ADDR_W-1:0] m_data_reg;
    logic              m_user_reg;

    // header memory
    hdr_t              hdr_mem [HEAP_UNITS];
    hdr_t              mem_rdata_reg;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    hdr_t              mem_wdata;

    // decoded request beat
    logic              in_action;
    logic              in_phys;
    logic [SIZE_W-1:0] in_size;
    logic [ADDR_W-1:0] in_addr;
    logic              in_beat;

    // walk and free arithmetic
    hdr_t              hdr;
    logic              hdr_fit;
    logic [PW-1:0]     step_pos;
    logic [PW-1:0]     new_end;
    logic              new_over;
    logic              reuse_over;
    logic              walk_over;
    logic [ADDR_W-1:0] free_pos;
    logic              free_in_range;
    logic              out_free;
    logic [ADDR_W-1:0] result_addr;

    assign in_action = s_axis_tuser[0];
    assign in_phys   = s_axis_tuser[1];
    assign in_size   = s_axis_tdata[SIZE_W-1:0];
    assign in_addr   = s_axis_tdata[SIZE_W+ADDR_W-1:SIZE_W];
    assign in_beat   = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // header as seen by the walk; entry 0 reads as an end marker until written
    assign hdr        = rd_zero_reg ? hdr_t'('0) : mem_rdata_reg;
    assign hdr_fit    = !hdr.rsv && ((hdr.size == '0) || (hdr.size >= req_reg));
    assign step_pos   = p_reg + HDR_P + PW'(hdr.size);
    assign new_end    = p_reg + HDR_P + PW'(req_reg);
    assign new_over   = (new_end + HDR_P) > HEAP_P;
    assign reuse_over = step_pos > HEAP_P;
    assign walk_over  = (p_reg + HDR_P) > HEAP_P;

    // free position: payload address less arena base and header, mod 2^16
    assign free_pos      = phys_addr_reg - arena_base_reg - HDR_A;
    assign free_in_range = {1'b0, free_pos} < HEAP_A;

    assign out_free    = !m_valid_reg || m_axis_tready;
    assign result_addr = found_reg ? (out_bias_reg + ADDR_W'(p_reg)) : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                    state_next = (in_action == ACT_FREE) ? S_FREE_RD : S_READ;
            end
            S_READ:
            begin
                state_next = walk_over ? S_DONE : S_EVAL;
            end
            S_EVAL:
            begin
                if (!hdr_fit)
                    state_next = S_READ;
                else if (hdr.size == '0)
                    state_next = new_over ? S_DONE : S_WR_HDR;
                else
                    state_next = S_DONE;
            end
            S_WR_HDR:  state_next = S_DONE;
            S_FREE_RD: state_next = free_in_range ? S_FREE_WR : S_DONE;
            S_FREE_WR: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = p_reg[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = p_reg[AW-1:0];
        mem_wdata = '0;
        case (state_reg)
            S_READ:
            begin
                mem_re = !walk_over;
            end
            S_EVAL:
            begin
                if (hdr_fit && (hdr.size == '0) && !new_over)
                begin
                    // new end marker after the appended block
                    mem_we    = 1'b1;
                    mem_waddr = new_end[AW-1:0];
                    mem_wdata = '0;
                end
                else if (hdr_fit && (hdr.size != '0) && !reuse_over)
                begin
                    // reuse keeps the recorded size
                    mem_we    = 1'b1;
                    mem_wdata = '{rsv: 1'b1, size: hdr.size};
                end
            end
            S_WR_HDR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{rsv: 1'b1, size: req_reg};
            end
            S_FREE_RD:
            begin
                mem_re    = free_in_range;
                mem_raddr = free_pos[AW-1:0];
            end
            S_FREE_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{rsv: 1'b0, size: hdr.size};
            end
            default:
            begin
                mem_re = 1'b0;
                mem_we = 1'b0;
            end
        endcase
    end

    // header memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            hdr_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= hdr_mem[mem_raddr];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_base_reg  <= '0;
            virt_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ARENA_BASE)
                arena_base_reg <= cfg_data;
            else
                virt_offset_reg <= cfg_data;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            e0_written_reg <= 1'b0;
            rd_zero_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_we && (mem_waddr == '0))
                e0_written_reg <= 1'b1;
            if (mem_re)
                rd_zero_reg <= (mem_raddr == '0) && !e0_written_reg;
            if (state_reg == S_DONE && out_free)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    p_reg         <= '0;
                    req_reg       <= (in_size == '0) ? SIZE_W'(1) : in_size;
                    phys_addr_reg <= in_phys ? in_addr : (in_addr - virt_offset_reg);
                    out_bias_reg  <= arena_base_reg + virt_offset_reg + HDR_A;
                    found_reg     <= 1'b0;
                    nospace_reg   <= (in_action == ACT_ALLOC);
                end
            end
            S_EVAL:
            begin
                if (!hdr_fit)
                    p_reg <= step_pos;
                else if (hdr.size == '0)
                begin
                    found_reg   <= !new_over;
                    nospace_reg <= new_over;
                end
                else
                begin
                    found_reg   <= !reuse_over;
                    nospace_reg <= reuse_over;
                end
            end
            S_FREE_RD:
            begin
                p_reg <= PW'(free_pos[AW-1:0]);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_data_reg <= result_addr;
                    m_user_reg <= nospace_reg ? STATUS_NOSPACE : STATUS_OK;
                end
            end
            default:
            begin
                p_reg <= p_reg;
            end
        endcase
    end

    // checks on the walk and the result
    `FFBA_ASSERT_SAME(a_walk_in_arena, clk, rst_n, state_reg == S_EVAL, p_reg < HEAP_P)
    `FFBA_ASSERT_SAME(a_nospace_zero_addr, clk, rst_n, m_valid_reg && (m_user_reg == STATUS_NOSPACE), m_data_reg == '0)
    `FFBA_ASSERT_NEXT(a_beat_starts_work, clk, rst_n, in_beat, state_reg != S_IDLE)
    `FFBA_ASSERT_ALWAYS(a_entry0_flag_sticky, clk, rst_n, !$fell(e0_written_reg))

endmodule
